[hdl/chbm_pkg.sv]
// Shared types and constants of the consistent-hash bucket mapper.
`default_nettype none
package chbm_pkg;
  localparam int MAX_BUCKETS = 1024;
  localparam int BKT_W       = 10;
  localparam int CNT_W       = 11;
  localparam int KEY_W       = 64;
  localparam int ROW_BITS    = 32;
  localparam int ROWS        = MAX_BUCKETS / ROW_BITS;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int LANE_W      = $clog2(ROW_BITS);
  localparam int CFG_IDX_W   = 2;
  localparam int MIX_SHIFT   = 33;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_MAP    = 2'd0;
  localparam op_t OP_ADD    = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_REFUSED = 2'd1;
  localparam status_t ST_RANGE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ACTIVE = 2'd1;

  localparam logic [KEY_W-1:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [KEY_W-1:0] MIX_MUL_A  = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_MUL_B  = 64'hc4ceb9fe1a85ec53;
endpackage
`default_nettype wire

[hdl/consistent_hash_bucket_mapper_top.sv]
// Map: one probe per cycle from the bitmap RAM, 1 .. N probes, N the effective bucket count.
// Hashing: two mixes on one shared 32x32 multiplier, two mods of the 64-bit key, 4 bits a cycle.
// Add / remove: read-modify-write of one 32-bit bitmap row; out of range or unused op: straight to the response.
// One item at a time; the next beat is taken while a result waits in the output register.
// Reset and every config write to the bucket count or initial active count start a sweep that
// rebuilds all 32 bitmap rows, one row a cycle; no input beat is taken during the sweep.
`default_nettype none
module consistent_hash_bucket_mapper_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [chbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [chbm_pkg::CNT_W-1:0]        cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire chbm_pkg::op_t                     in_op,
  input  wire logic [chbm_pkg::KEY_W-1:0]        in_key,
  input  wire logic [chbm_pkg::BKT_W-1:0]        in_bucket,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output chbm_pkg::status_t                      out_status,
  output logic [chbm_pkg::BKT_W-1:0]             out_mapped_bucket,
  output logic [chbm_pkg::CNT_W-1:0]             out_active_count
);
  import chbm_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MIX, S_MOD, S_PSTART, S_PROBE, S_UPD_RD, S_UPD, S_RESP
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   bucket_count_r, initial_active_r, active_total_r;
  logic [ROW_W-1:0]   init_row_r;
  op_t                op_r;
  logic [KEY_W-1:0]   key_r, k_r, acc_r, prod_r;
  logic [BKT_W-1:0]   bucket_r, pos_r, stride_r;
  logic               salt_r, mul_b_r;
  logic [2:0]         ph_r;
  logic [3:0]         step_r;
  logic [CNT_W-1:0]   rem_r, probe_cnt_r;
  status_t            res_status_r;
  logic [BKT_W-1:0]   res_mapped_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [BKT_W-1:0]   out_mapped_r;
  logic [CNT_W-1:0]   out_count_r;

  logic [CNT_W-1:0]   n_eff, a_eff, div_d, rem_nxt;
  logic [KEY_W-1:0]   kx, mix_t, prod_nxt, c_sel;
  logic [31:0]        mul_a, mul_b;
  logic [BKT_W-1:0]   pos_next;
  logic [ROW_BITS-1:0] row_mask, rd_data, wr_data;
  logic [ROW_W-1:0]   rd_addr, wr_addr;
  logic               wr_en, lane_bit, add_ok, rem_ok, cfg_hit;

  // effective N and A
  always_comb begin
    if (bucket_count_r < CNT_W'(2)) n_eff = CNT_W'(2);
    else if (bucket_count_r > CNT_W'(MAX_BUCKETS)) n_eff = CNT_W'(MAX_BUCKETS);
    else n_eff = bucket_count_r;
    if (initial_active_r < CNT_W'(1)) a_eff = CNT_W'(1);
    else if (initial_active_r > n_eff) a_eff = n_eff;
    else a_eff = initial_active_r;
  end

  assign cfg_hit = cfg_we && (cfg_index == CFG_BUCKET_COUNT || cfg_index == CFG_INITIAL_ACTIVE);

  // mix datapath: one 32x32 partial product per cycle
  always_comb begin
    kx       = k_r ^ (salt_r ? MIX_GOLDEN : '0);
    c_sel    = mul_b_r ? MIX_MUL_B : MIX_MUL_A;
    mul_a    = (ph_r == 3'd3) ? k_r[63:32] : k_r[31:0];
    mul_b    = (ph_r == 3'd2) ? c_sel[63:32] : c_sel[31:0];
    prod_nxt = {32'h0, mul_a} * {32'h0, mul_b};
    mix_t    = acc_r + {prod_r[31:0], 32'h0};
  end

  // restoring remainder, four dividend bits a cycle
  always_comb begin
    logic [CNT_W:0] r;
    div_d = salt_r ? (n_eff - CNT_W'(1)) : n_eff;
    r = {1'b0, rem_r};
    for (int j = 0; j < 4; j++) begin
      r = {r[CNT_W-1:0], k_r[KEY_W-1-j]};
      if (r >= {1'b0, div_d}) r = r - {1'b0, div_d};
    end
    rem_nxt = r[CNT_W-1:0];
  end

  // probe step: pos and stride are both below N
  always_comb begin
    logic [CNT_W-1:0] s;
    s = {1'b0, pos_r} + {1'b0, stride_r};
    if (s >= n_eff) s = s - n_eff;
    pos_next = s[BKT_W-1:0];
  end

  always_comb begin
    for (int b = 0; b < ROW_BITS; b++) begin
      row_mask[b] = ({1'b0, init_row_r, LANE_W'(b)} < a_eff);
    end
  end

  always_comb begin
    lane_bit = rd_data[bucket_r[LANE_W-1:0]];
    add_ok   = (op_r == OP_ADD) && !lane_bit && (active_total_r < n_eff);
    rem_ok   = (op_r == OP_REMOVE) && lane_bit && (active_total_r > CNT_W'(1));
    rd_addr  = '0;
    wr_addr  = bucket_r[BKT_W-1:LANE_W];
    wr_data  = rd_data ^ (ROW_BITS'(1) << bucket_r[LANE_W-1:0]);
    wr_en    = 1'b0;
    unique case (state_r)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_row_r;
        wr_data = row_mask;
      end
      S_PSTART: rd_addr = pos_r[BKT_W-1:LANE_W];
      S_PROBE:  rd_addr = pos_next[BKT_W-1:LANE_W];
      S_UPD_RD: rd_addr = bucket_r[BKT_W-1:LANE_W];
      S_UPD:    wr_en   = add_ok || rem_ok;
      default: ;
    endcase
  end

  chbm_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_mapped_bucket = out_mapped_r;
  assign out_active_count  = out_count_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      state_r          <= S_INIT;
      init_row_r       <= '0;
      bucket_count_r   <= CNT_W'(MAX_BUCKETS);
      initial_active_r <= CNT_W'(MAX_BUCKETS);
      active_total_r   <= CNT_W'(MAX_BUCKETS);
      out_valid_r      <= 1'b0;
    end else begin
      if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_INIT: begin
          active_total_r <= a_eff;
          init_row_r     <= init_row_r + ROW_W'(1);
          if (init_row_r == ROW_W'(ROWS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r         <= in_op;
            key_r        <= in_key;
            k_r          <= in_key;
            bucket_r     <= in_bucket;
            salt_r       <= 1'b0;
            mul_b_r      <= 1'b0;
            ph_r         <= 3'd0;
            res_mapped_r <= '0;
            if (in_op == OP_MAP) begin
              state_r <= S_MIX;
            end else if (in_op == OP_ADD || in_op == OP_REMOVE) begin
              if ({1'b0, in_bucket} >= n_eff) begin
                res_status_r <= ST_RANGE;
                state_r      <= S_RESP;
              end else begin
                state_r <= S_UPD_RD;
              end
            end else begin
              res_status_r <= ST_REFUSED;
              state_r      <= S_RESP;
            end
          end
        end
        S_MIX: begin
          ph_r <= ph_r + 3'd1;
          case (ph_r)
            3'd0: k_r <= kx ^ (kx >> MIX_SHIFT);
            3'd2: acc_r <= prod_r;
            3'd3: acc_r <= mix_t;
            3'd4: begin
              k_r <= mix_t ^ (mix_t >> MIX_SHIFT);
              if (!mul_b_r) begin
                mul_b_r <= 1'b1;
                ph_r    <= 3'd1;
              end else begin
                state_r <= S_MOD;
                step_r  <= '0;
                rem_r   <= '0;
              end
            end
            default: ;
          endcase
        end
        S_MOD: begin
          k_r    <= k_r << 4;
          rem_r  <= rem_nxt;
          step_r <= step_r + 4'd1;
          if (step_r == 4'd15) begin
            if (!salt_r) begin
              pos_r   <= rem_nxt[BKT_W-1:0];
              salt_r  <= 1'b1;
              k_r     <= key_r;
              mul_b_r <= 1'b0;
              ph_r    <= 3'd0;
              state_r <= S_MIX;
            end else begin
              stride_r <= rem_nxt[BKT_W-1:0] + BKT_W'(1);
              state_r  <= S_PSTART;
            end
          end
        end
        S_PSTART: begin
          probe_cnt_r <= '0;
          state_r     <= S_PROBE;
        end
        S_PROBE: begin
          if (rd_data[pos_r[LANE_W-1:0]]) begin
            res_status_r <= ST_OK;
            res_mapped_r <= pos_r;
            state_r      <= S_RESP;
          end else if (probe_cnt_r == n_eff - CNT_W'(1)) begin
            res_status_r <= ST_REFUSED;
            state_r      <= S_RESP;
          end else begin
            pos_r       <= pos_next;
            probe_cnt_r <= probe_cnt_r + CNT_W'(1);
          end
        end
        S_UPD_RD: state_r <= S_UPD;
        S_UPD: begin
          if (add_ok) active_total_r <= active_total_r + CNT_W'(1);
          if (rem_ok) active_total_r <= active_total_r - CNT_W'(1);
          res_status_r <= (add_ok || rem_ok) ? ST_OK : ST_REFUSED;
          state_r      <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_mapped_r <= res_mapped_r;
            out_count_r  <= active_total_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_INIT;
      endcase
      if (cfg_hit) begin
        if (cfg_index == CFG_BUCKET_COUNT) bucket_count_r <= cfg_wdata;
        else initial_active_r <= cfg_wdata;
        init_row_r <= '0;
        state_r    <= S_INIT;
      end
    end
  end
endmodule
`default_nettype wire

[hdl/chbm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module chbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire
